### rtl/core/bdrf_pkg.sv
// Shared constants, types and state codes for the decimal range finder.
`default_nettype none

package bdrf_pkg;

  // Digit capacity of each stored number
  localparam int MAX_DIGITS = 32;
  // Width of a length or lead-zero count (holds 0..MAX_DIGITS)
  localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
  // Width of an index into a digit store
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  // Difference has one more digit than the operands
  localparam int RES_DEPTH  = MAX_DIGITS + 1;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  // One classified digit request
  typedef struct packed {
    logic [3:0] digit;
    logic       negative;
    logic       eon;
    logic       eos;
  } token_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    token_t tok;
  } tokq_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_SUB  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### rtl/core/bdrf_ifs.sv
// Valid/ready channel interfaces for digit requests and result digits.
`default_nettype none

interface bdrf_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic       negative;
  logic       end_of_number;
  logic       end_of_set;

  modport source (output valid, digit, negative, end_of_number, end_of_set, input ready);
  modport sink   (input valid, digit, negative, end_of_number, end_of_set, output ready);
endinterface

interface bdrf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] result_digit;
  logic       last;
  logic       overflow;

  modport source (output valid, result_digit, last, overflow, input ready);
  modport sink   (input valid, result_digit, last, overflow, output ready);
endinterface

`default_nettype wire

### rtl/core/bdrf_front.sv
// Front end: accept digit requests, classify them and buffer them in a short queue.
`default_nettype none

module bdrf_front
  import bdrf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  bdrf_in_if.sink in_ch,
  output tokq_t  q_o,
  input  logic   q_pop
);

  token_t     ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  token_t     tok_c;
  logic       push;
  logic       pop;

  // Clamp the digit and let end of set also end the number
  always_comb begin
    tok_c.digit    = (in_ch.digit > DIGIT_MAX) ? DIGIT_MAX : in_ch.digit;
    tok_c.negative = in_ch.negative;
    tok_c.eon      = in_ch.end_of_number | in_ch.end_of_set;
    tok_c.eos      = in_ch.end_of_set;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid & in_ch.ready;
  assign pop         = q_pop & (cnt_r != 2'd0);
  assign q_o.valid   = (cnt_r != 2'd0);
  assign q_o.tok     = ent_r[rp_r];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= tok_c;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/bdrf_back.sv
// Back end: store digits, track max and min, subtract and emit the difference.
`default_nettype none

module bdrf_back
  import bdrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tokq_t       q_i,
  output logic        q_pop,
  bdrf_out_if.source  out_ch
);

  state_t st_r;

  logic [3:0] cur_mem [MAX_DIGITS];
  logic [3:0] lg_mem  [MAX_DIGITS];
  logic [3:0] sm_mem  [MAX_DIGITS];
  logic [3:0] res_mem [RES_DEPTH];

  logic [LEN_W-1:0] len_r, lz_r, lenl_r, lzl_r, lens_r, lzs_r;
  logic             sgn_r, sgnl_r, sgns_r, seen_r, ovf_r, eos_r;
  logic [LEN_W-1:0] k_r;
  logic             decl_r, gtl_r, decs_r, gts_r;
  logic [LEN_W-1:0] i_r, top_r;
  logic             carry_r;
  logic [3:0]       rd_r;

  logic       out_valid_r, out_last_r, out_ovf_r;
  logic [3:0] out_digit_r;

  logic [LEN_W-1:0] ea, el, es;
  logic [IDX_W-1:0] ac, al, as_;
  logic [3:0]       dc, dl, ds;
  logic             sa, sl, ss;
  logic             mgt_l, mlt_l, mgt_s, mlt_s;
  logic             cur_gt, cur_lt, upd_l, upd_s;
  logic [3:0]       a, b, x, y, v;
  logic [4:0]       need, sum;
  logic             c;
  logic [LEN_W-1:0] top_nxt;
  logic             popped, out_load;

  assign q_pop  = (st_r == ST_IDLE) & q_i.valid;
  assign popped = q_pop;

  // Effective lengths, read addresses and digits
  always_comb begin
    ea  = len_r - lz_r;
    el  = lenl_r - lzl_r;
    es  = lens_r - lzs_r;
    ac  = IDX_W'(lz_r + k_r);
    al  = (st_r == ST_SUB) ? IDX_W'(lenl_r - LEN_W'(1) - i_r) : IDX_W'(lzl_r + k_r);
    as_ = (st_r == ST_SUB) ? IDX_W'(lens_r - LEN_W'(1) - i_r) : IDX_W'(lzs_r + k_r);
    dc  = cur_mem[ac];
    dl  = lg_mem[al];
    ds  = sm_mem[as_];
    sa  = sgn_r  & (ea != '0);
    sl  = sgnl_r & (el != '0);
    ss  = sgns_r & (es != '0);
  end

  // Decide whether the finished number is a new max or min
  always_comb begin
    mgt_l  = (ea != el) ? (ea > el) : (decl_r &  gtl_r);
    mlt_l  = (ea != el) ? (ea < el) : (decl_r & ~gtl_r);
    mgt_s  = (ea != es) ? (ea > es) : (decs_r &  gts_r);
    mlt_s  = (ea != es) ? (ea < es) : (decs_r & ~gts_r);
    cur_gt = (sa != sl) ? ~sa : (sa ? mlt_l : mgt_l);
    cur_lt = (sa != ss) ?  sa : (sa ? mgt_s : mlt_s);
    upd_l  = ~seen_r | cur_gt;
    upd_s  = ~seen_r | cur_lt;
  end

  // One digit of max minus min with carry
  always_comb begin
    a    = (i_r < lenl_r) ? dl : 4'd0;
    b    = (i_r < lens_r) ? ds : 4'd0;
    x    = sl ? b : a;
    y    = sl ? a : b;
    need = {1'b0, y} + {4'd0, carry_r};
    sum  = {1'b0, a} + {1'b0, b} + {4'd0, carry_r};
    if (sl == ss) begin
      if ({1'b0, x} >= need) begin
        v = 4'((({1'b0, x}) - need));
        c = 1'b0;
      end else begin
        v = 4'(({1'b0, x} + RADIX) - need);
        c = 1'b1;
      end
    end else begin
      c = (sum >= RADIX);
      v = c ? 4'(sum - RADIX) : sum[3:0];
    end
    top_nxt = (v != 4'd0) ? i_r : top_r;
  end

  assign out_load = (st_r == ST_OUT) & (~out_valid_r | out_ch.ready);

  // Digit stores and result memory
  always_ff @(posedge clk) begin
    if (popped && (len_r < LEN_W'(MAX_DIGITS))) begin
      cur_mem[IDX_W'(len_r)] <= q_i.tok.digit;
    end
    if (st_r == ST_UPD) begin
      if (upd_l) lg_mem <= cur_mem;
      if (upd_s) sm_mem <= cur_mem;
    end
    if (st_r == ST_SUB) begin
      res_mem[i_r] <= v;
    end
    if (st_r == ST_RD) begin
      rd_r <= res_mem[i_r];
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_digit_r <= rd_r;
      out_last_r  <= (i_r == '0);
      out_ovf_r   <= ovf_r;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      len_r       <= '0;
      lz_r        <= '0;
      sgn_r       <= 1'b0;
      lenl_r      <= '0;
      lzl_r       <= '0;
      sgnl_r      <= 1'b0;
      lens_r      <= '0;
      lzs_r       <= '0;
      sgns_r      <= 1'b0;
      seen_r      <= 1'b0;
      ovf_r       <= 1'b0;
      eos_r       <= 1'b0;
      k_r         <= '0;
      decl_r      <= 1'b0;
      gtl_r       <= 1'b0;
      decs_r      <= 1'b0;
      gts_r       <= 1'b0;
      i_r         <= '0;
      top_r       <= '0;
      carry_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // raise the result on load, drop it once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (popped) begin
            if (len_r == '0) sgn_r <= q_i.tok.negative;
            if (len_r < LEN_W'(MAX_DIGITS)) begin
              len_r <= len_r + LEN_W'(1);
              if ((lz_r == len_r) && (q_i.tok.digit == 4'd0)) lz_r <= lz_r + LEN_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (q_i.tok.eon) begin
              eos_r  <= q_i.tok.eos;
              k_r    <= '0;
              decl_r <= 1'b0;
              decs_r <= 1'b0;
              st_r   <= seen_r ? ST_SCAN : ST_UPD;
            end
          end
        end
        ST_SCAN: begin
          // compare significant digits against max and min
          if (k_r == ea) begin
            st_r <= ST_UPD;
          end else begin
            if (!decl_r && (dc != dl)) begin
              decl_r <= 1'b1;
              gtl_r  <= (dc > dl);
            end
            if (!decs_r && (dc != ds)) begin
              decs_r <= 1'b1;
              gts_r  <= (dc > ds);
            end
            k_r <= k_r + LEN_W'(1);
          end
        end
        ST_UPD: begin
          if (upd_l) begin
            lenl_r <= len_r;
            lzl_r  <= lz_r;
            sgnl_r <= sgn_r;
          end
          if (upd_s) begin
            lens_r <= len_r;
            lzs_r  <= lz_r;
            sgns_r <= sgn_r;
          end
          len_r  <= '0;
          lz_r   <= '0;
          sgn_r  <= 1'b0;
          seen_r <= 1'b1;
          if (eos_r) begin
            i_r     <= '0;
            top_r   <= '0;
            carry_r <= 1'b0;
            st_r    <= ST_SUB;
          end else begin
            st_r <= ST_IDLE;
          end
        end
        ST_SUB: begin
          // subtract from the least significant digit up
          carry_r <= c;
          top_r   <= top_nxt;
          if (i_r == LEN_W'(MAX_DIGITS)) begin
            i_r  <= top_nxt;
            st_r <= ST_RD;
          end else begin
            i_r <= i_r + LEN_W'(1);
          end
        end
        ST_RD: begin
          st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            if (i_r == '0) begin
              seen_r <= 1'b0;
              ovf_r  <= 1'b0;
              lenl_r <= '0;
              lzl_r  <= '0;
              sgnl_r <= 1'b0;
              lens_r <= '0;
              lzs_r  <= '0;
              sgns_r <= 1'b0;
              st_r   <= ST_IDLE;
            end else begin
              i_r  <= i_r - LEN_W'(1);
              st_r <= ST_RD;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_digit = out_digit_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.overflow     = out_ovf_r;

endmodule

`default_nettype wire

### rtl/core/big_decimal_range_finder_top.sv
// Decimal range finder: streams signed decimal numbers, emits max minus min.
//
// in_ch carries one digit request per handshake, most significant digit first,
// with the sign on the first digit and end_of_number / end_of_set markers.
// out_ch returns the digits of max minus min, most significant first, leading
// zeros suppressed, last set on the final digit and overflow on every digit.
// A two-entry queue parts the front end from the sequencer in the back end.
// Plain digits retire at one per cycle while the back end is idle. A number's
// end scans its significant digits against max and min (not for the first
// number of a set), then updates them. A set's end adds a carry subtraction
// over MAX_DIGITS + 1 positions and one result memory read per result digit.
// While the back end is busy the queue absorbs up to two more requests and
// then lowers in_ch.ready. A stalled receiver holds the result register and
// the sequencer waits on it. Synchronous reset empties the queue, clears all
// lengths, signs and flags and starts a new set; digit stores need no clearing.
`default_nettype none

module big_decimal_range_finder_top
  import bdrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bdrf_in_if.sink    in_ch,
  bdrf_out_if.source out_ch
);

  tokq_t q;
  logic  q_pop;

  bdrf_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_o   (q),
    .q_pop (q_pop)
  );

  bdrf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_i    (q),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // nothing follows the last digit of a difference
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=> !out_ch.valid)
    else $error("result continued after last digit");

  // result digits stay decimal
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.result_digit <= DIGIT_MAX))
    else $error("result digit above nine");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

### sim/big_decimal_range_finder_top_tb.sv
// Testbench for the decimal range finder: directed and random digit sets, checked per digit.
`timescale 1ns / 100ps

module big_decimal_range_finder_top_tb;
  import bdrf_pkg::*;

  // One expected result digit
  typedef struct packed {
    logic [3:0] digit;
    logic       last;
    logic       overflow;
  } diff_digit_t;

  logic clk;
  logic rst_n;
  bdrf_in_if  in_ch();
  bdrf_out_if out_ch();

  big_decimal_range_finder_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow state of the range finder
  logic [3:0] cur_dig [MAX_DIGITS];
  int         cur_len;
  bit         cur_neg;
  logic [3:0] hi_dig [MAX_DIGITS];
  int         hi_len;
  bit         hi_neg;
  logic [3:0] lo_dig [MAX_DIGITS];
  int         lo_len;
  bit         lo_neg;
  bit         any_seen;
  bit         ovf_seen;

  diff_digit_t diff_q[$];
  int  errors;
  int  cycles;
  bit  send_idle_en;
  bit  recv_idle_en;

  localparam int CYCLE_LIMIT = 1200000;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic clear_shadow();
    cur_len = 0; cur_neg = 0;
    hi_len = 0; hi_neg = 0;
    lo_len = 0; lo_neg = 0;
    any_seen = 0; ovf_seen = 0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      cur_dig[i] = '0; hi_dig[i] = '0; lo_dig[i] = '0;
    end
  endtask

  function automatic int lead_zeros(logic [3:0] d[MAX_DIGITS], int len);
    int k;
    k = 0;
    while (k < len && d[k] == 0) k++;
    return k;
  endfunction

  // Signed numeric compare of current number against a stored one
  function automatic int cmp_current(logic [3:0] bd[MAX_DIGITS], int bl, bit bs);
    int oa, ob, ea, eb, m;
    bit sa, sb;
    oa = lead_zeros(cur_dig, cur_len);
    ob = lead_zeros(bd, bl);
    ea = cur_len - oa;
    eb = bl - ob;
    sa = cur_neg && ea > 0;
    sb = bs && eb > 0;
    m = 0;
    if (sa != sb) return sa ? -1 : 1;
    if (ea != eb) m = (ea > eb) ? 1 : -1;
    else begin
      for (int k = 0; k < ea; k++) begin
        if (cur_dig[oa + k] != bd[ob + k]) begin
          m = (cur_dig[oa + k] > bd[ob + k]) ? 1 : -1;
          break;
        end
      end
    end
    return sa ? -m : m;
  endfunction

  // Push the digits of max minus min, most significant first
  task automatic predict_range();
    logic [3:0] diff[MAX_DIGITS + 1];
    bit sl, ss;
    int carry, a, b, x, y, v, top;
    diff_digit_t e;
    sl = hi_neg && lead_zeros(hi_dig, hi_len) < hi_len;
    ss = lo_neg && lead_zeros(lo_dig, lo_len) < lo_len;
    carry = 0;
    for (int i = 0; i <= MAX_DIGITS; i++) begin
      a = (i < hi_len) ? hi_dig[hi_len - 1 - i] : 0;
      b = (i < lo_len) ? lo_dig[lo_len - 1 - i] : 0;
      if (sl == ss) begin
        x = sl ? b : a;
        y = (sl ? a : b) + carry;
        if (x >= y) begin
          v = x - y; carry = 0;
        end else begin
          v = x + 10 - y; carry = 1;
        end
      end else begin
        v = a + b + carry;
        carry = (v >= 10);
        if (carry) v -= 10;
      end
      diff[i] = v[3:0];
    end
    top = 0;
    for (int i = MAX_DIGITS; i > 0; i--) begin
      if (diff[i] != 0) begin
        top = i;
        break;
      end
    end
    for (int i = top; i >= 0; i--) begin
      e.digit = diff[i];
      e.last = (i == 0);
      e.overflow = ovf_seen;
      diff_q.push_back(e);
    end
    clear_shadow();
  endtask

  // Advance the shadow state by one accepted request
  task automatic model_request(logic [3:0] dg, bit neg, bit eon, bit eos);
    if (dg > DIGIT_MAX) dg = DIGIT_MAX;
    if (cur_len == 0) cur_neg = neg;
    if (cur_len < MAX_DIGITS) begin
      cur_dig[cur_len] = dg;
      cur_len++;
    end else ovf_seen = 1;
    if (!eon && !eos) return;
    if (!any_seen) begin
      hi_dig = cur_dig; lo_dig = cur_dig;
      hi_len = cur_len; lo_len = cur_len;
      hi_neg = cur_neg; lo_neg = cur_neg;
      any_seen = 1;
    end else begin
      if (cmp_current(hi_dig, hi_len, hi_neg) > 0) begin
        hi_dig = cur_dig; hi_len = cur_len; hi_neg = cur_neg;
      end
      if (cmp_current(lo_dig, lo_len, lo_neg) < 0) begin
        lo_dig = cur_dig; lo_len = cur_len; lo_neg = cur_neg;
      end
    end
    cur_len = 0;
    cur_neg = 0;
    if (eos) predict_range();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Send one request; called at a falling edge, returns at a falling edge with valid
  // still high, to be lowered by the next idle burst or by a drain
  task automatic send_digit(logic [3:0] dg, bit neg, bit eon, bit eos);
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.digit <= dg;
    in_ch.negative <= neg;
    in_ch.end_of_number <= eon;
    in_ch.end_of_set <= eos;
    do @(posedge clk); while (!in_ch.ready);
    model_request(dg, neg, eon, eos);
    @(negedge clk);
  endtask

  // Send one number of given length; first digit nonzero unless zeros requested
  task automatic send_number(int len, bit neg, bit eos, bit lead_zero);
    logic [3:0] d;
    for (int i = 0; i < len; i++) begin
      if (i == 0 && !lead_zero) d = 4'($urandom_range(1, 9));
      else d = 4'($urandom_range(0, 9));
      send_digit(d, neg, i == len - 1, eos && i == len - 1);
    end
  endtask

  // Accept and check results
  initial begin
    diff_digit_t want;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (diff_q.size() == 0) report_mismatch("unexpected digit", out_ch.result_digit, -1);
        else begin
          want = diff_q.pop_front();
          if (out_ch.result_digit !== want.digit)
            report_mismatch("result_digit", out_ch.result_digit, want.digit);
          if (out_ch.last !== want.last) report_mismatch("last", out_ch.last, want.last);
          if (out_ch.overflow !== want.overflow)
            report_mismatch("overflow", out_ch.overflow, want.overflow);
        end
      end
    end
  end

  // Hold the sender until every expected result has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (diff_q.size() != 0) @(negedge clk);
  endtask

  // Extremes, signs, ties, zeros, oddities
  task automatic test_directed();
    send_digit(4'd0, 1'b1, 1'b0, 1'b1);             // lone negative zero
    send_digit(4'd7, 1'b0, 1'b1, 1'b1);             // single number
    send_digit(4'd15, 1'b1, 1'b1, 1'b0);            // digit above nine
    send_digit(4'd9, 1'b0, 1'b1, 1'b0);
    send_digit(4'd9, 1'b0, 1'b1, 1'b1);             // tie with max
    send_number(MAX_DIGITS, 1'b1, 1'b0, 1'b0);      // widest negative
    send_number(MAX_DIGITS, 1'b0, 1'b1, 1'b0);      // widest positive, carry out
    send_number(MAX_DIGITS + 3, 1'b0, 1'b0, 1'b0);  // overflow
    send_number(2, 1'b1, 1'b1, 1'b1);
    send_digit(4'd0, 1'b0, 1'b0, 1'b0);             // leading zeros
    send_digit(4'd0, 1'b0, 1'b0, 1'b0);
    send_digit(4'd5, 1'b0, 1'b1, 1'b0);
    send_digit(4'd5, 1'b1, 1'b1, 1'b1);
    wait_drained();
  endtask

  // Mostly well-formed sets with random content, some raw noise
  task automatic test_random(int n_req);
    int sent, len, nnum;
    sent = 0;
    while (sent < n_req) begin
      if ($urandom_range(0, 9) == 0) begin
        send_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        nnum = $urandom_range(1, 5);
        for (int k = 0; k < nnum; k++) begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
          send_number(len, 1'($urandom_range(0, 1)), k == nnum - 1,
                      $urandom_range(0, 4) == 0);
          sent += len;
        end
      end
    end
    send_digit(4'($urandom_range(0, 9)), 1'b0, 1'b1, 1'b1); // close any open set
    wait_drained();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    send_idle_en = 0;
    recv_idle_en = 0;
    in_ch.valid = 1'b0;
    in_ch.digit = '0;
    in_ch.negative = 1'b0;
    in_ch.end_of_number = 1'b0;
    in_ch.end_of_set = 1'b0;
    clear_shadow();
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    send_idle_en = 1;
    recv_idle_en = 1;
    test_random(180);
    send_idle_en = 0;
    recv_idle_en = 0;
    test_random(80);
    repeat (200) @(negedge clk);
    if (errors == 0 && diff_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
